### rtl/core/kpdc_pkg.sv
// Package for the key press duration classifier: types, widths, register
// indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kpdc_pkg;

	localparam int KEY_FIELD_W  = 4;
	localparam int NUM_KEYS_DEF = 4;
	localparam int COUNT_W      = 9;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8;
	localparam int THR_W        = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic             PRESS_LEVEL_RST   = 1'b0;
	localparam logic [THR_W-1:0] SHORT_MIN_RST     = 8'd2;
	localparam logic [THR_W-1:0] SHORT_MAX_RST     = 8'd100;
	localparam logic [THR_W-1:0] LONG_MIN_RST      = 8'd150;
	localparam logic [THR_W-1:0] VERY_LONG_MIN_RST = 8'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_LEVEL   = 3'd0,
		CFG_SHORT_MIN     = 3'd1,
		CFG_SHORT_MAX     = 3'd2,
		CFG_LONG_MIN      = 3'd3,
		CFG_VERY_LONG_MIN = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             press_level;
		logic [THR_W-1:0] short_min;
		logic [THR_W-1:0] short_max;
		logic [THR_W-1:0] long_min;
		logic [THR_W-1:0] very_long_min;
	} cfg_t;

	typedef struct packed {
		logic [KEY_FIELD_W-1:0] key_levels;
		logic [KEY_FIELD_W-1:0] clear_short_mask;
		logic [KEY_FIELD_W-1:0] clear_long_mask;
		logic [KEY_FIELD_W-1:0] clear_very_long_mask;
	} in_word_t;

	typedef struct packed {
		logic [KEY_FIELD_W-1:0] pressed_now;
		logic [KEY_FIELD_W-1:0] short_flags;
		logic [KEY_FIELD_W-1:0] long_flags;
		logic [KEY_FIELD_W-1:0] very_long_flags;
	} out_word_t;

	// Per-key status handed from a key unit to the result register
	typedef struct packed {
		logic pressed;
		logic short_f;
		logic long_f;
		logic very_long_f;
	} key_stat_t;

	// Per-key tick input handed from the input register to a key unit
	typedef struct packed {
		logic level;
		logic clr_short;
		logic clr_long;
		logic clr_very_long;
	} key_tick_t;

endpackage : kpdc_pkg

`default_nettype wire

### rtl/core/key_press_duration_classifier_top.sv
// Top level of the key press duration classifier: input register, key units,
// result register. Depends on kpdc_pkg, kpdc_cfg_regs, kpdc_key_unit.
//
//   channel | signals                                | direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_stall, in_word            | tick word in
//   output  | out_valid, out_stall, out_word         | status word out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One tick word per cycle sustained while in_stall is low; an accepted word enters
// the input register and moves through the per-key update logic into the result
// register once that register is free, and its status word is offered from there.
// Reset clears all key state and loads the register defaults; no clearing pass.
// A stalled result holds; a new word still enters the input register, and
// in_stall rises only when both the input and result registers are full.
`timescale 1ns / 1ps
`default_nettype none

module key_press_duration_classifier_top
	import kpdc_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_word_t              in_word,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_word_t                  out_word,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	logic      s1_valid_q;
	in_word_t  word_s1;
	logic      out_valid_q;
	out_word_t word_s2;
	logic      s2_take;
	logic      in_take;
	key_stat_t stat [NUM_KEYS];
	out_word_t result;

	kpdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: the result register frees when empty or taken
	assign s2_take  = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (s2_take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_word;
		end
	end

	// Key units; keys past the field width see level zero and no clears
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		key_tick_t tick;
		if (k < KEY_FIELD_W) begin : g_in
			assign tick.level         = word_s1.key_levels[k];
			assign tick.clr_short     = word_s1.clear_short_mask[k];
			assign tick.clr_long      = word_s1.clear_long_mask[k];
			assign tick.clr_very_long = word_s1.clear_very_long_mask[k];
		end else begin : g_none
			assign tick = '0;
		end

		kpdc_key_unit u_key (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg),
			.advance (s2_take),
			.tick    (tick),
			.stat    (stat[k])
		);
	end

	// Gather the visible keys into the result word
	always_comb begin
		result = '0;
		for (int k = 0; k < NUM_KEYS && k < KEY_FIELD_W; k++) begin
			result.pressed_now[k]     = stat[k].pressed;
			result.short_flags[k]     = stat[k].short_f;
			result.long_flags[k]      = stat[k].long_f;
			result.very_long_flags[k] = stat[k].very_long_f;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			word_s2 <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = word_s2;

`ifndef SYNTHESIS
	a_s1_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> s1_valid_q)
		else $error("accepted word did not reach the input register");

	a_s2_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s2_take |=> out_valid_q)
		else $error("advanced word did not reach the result register");

	a_short_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((word_s2.short_flags
			& (word_s2.long_flags | word_s2.very_long_flags)) == '0))
		else $error("short flag set together with a long flag");
`endif

endmodule : key_press_duration_classifier_top

`default_nettype wire

### rtl/core/kpdc_cfg_regs.sv
// Configuration register file of the key press duration classifier.
// Depends on kpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpdc_cfg_regs
	import kpdc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg         = cfg_q;

	// Decode the index and load the addressed register; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level   <= PRESS_LEVEL_RST;
			cfg_q.short_min     <= SHORT_MIN_RST;
			cfg_q.short_max     <= SHORT_MAX_RST;
			cfg_q.long_min      <= LONG_MIN_RST;
			cfg_q.very_long_min <= VERY_LONG_MIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PRESS_LEVEL:   cfg_q.press_level   <= cfg_data[0];
				CFG_SHORT_MIN:     cfg_q.short_min     <= cfg_data;
				CFG_SHORT_MAX:     cfg_q.short_max     <= cfg_data;
				CFG_LONG_MIN:      cfg_q.long_min      <= cfg_data;
				CFG_VERY_LONG_MIN: cfg_q.very_long_min <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule : kpdc_cfg_regs

`default_nettype wire

### rtl/core/kpdc_key_unit.sv
// State and tick update of one key: previous level, hold counter, sticky flags.
// Depends on kpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpdc_key_unit
	import kpdc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      advance,
	input  wire key_tick_t tick,
	output key_stat_t      stat
);

	logic               prev_q;
	logic [COUNT_W-1:0] count_q;
	logic               short_q;
	logic               long_q;
	logic               very_long_q;

	logic               now;
	logic [COUNT_W-1:0] count_inc;
	logic [COUNT_W-1:0] count_d;
	logic               short_d;
	logic               long_d;
	logic               very_long_d;

	// Compute the next key state for this tick
	always_comb begin
		now         = (tick.level == cfg.press_level);
		count_inc   = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
		count_d     = count_q;
		short_d     = short_q & ~tick.clr_short;
		long_d      = long_q & ~tick.clr_long;
		very_long_d = very_long_q & ~tick.clr_very_long;

		if (!prev_q && now) begin
			// press edge: restart everything
			count_d     = '0;
			short_d     = 1'b0;
			long_d      = 1'b0;
			very_long_d = 1'b0;
		end else if (prev_q && now) begin
			if (count_inc > {1'b0, cfg.long_min}) begin
				long_d  = 1'b1;
				count_d = '0;
			end else if (long_d && (count_inc > {1'b0, cfg.very_long_min})) begin
				very_long_d = 1'b1;
				count_d     = '0;
			end else begin
				count_d = count_inc;
			end
		end else if (prev_q && !now) begin
			// release: short press only inside the window and with no long flag
			if ((count_q > {1'b0, cfg.short_min}) && (count_q < {1'b0, cfg.short_max})
					&& !long_d && !very_long_d) begin
				short_d = 1'b1;
			end
			count_d = '0;
		end
	end

	// Commit the update when the tick leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b0;
			count_q     <= '0;
			short_q     <= 1'b0;
			long_q      <= 1'b0;
			very_long_q <= 1'b0;
		end else if (advance) begin
			prev_q      <= now;
			count_q     <= count_d;
			short_q     <= short_d;
			long_q      <= long_d;
			very_long_q <= very_long_d;
		end
	end

	assign stat.pressed     = now;
	assign stat.short_f     = short_d;
	assign stat.long_f      = long_d;
	assign stat.very_long_f = very_long_d;

endmodule : kpdc_key_unit

`default_nettype wire
